@@ rtl/core/sact_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sact_pkg
// Shared types and constants for the set-associative cache tag store.
// ----------------------------------------------------------------------------
package sact_pkg;

    localparam int ADDR_W  = 64;
    localparam int CNT_W   = 32;
    localparam int LOFF_W  = 5;
    localparam int KIND_W  = 2;

    localparam logic [LOFF_W-1:0] LOFF_RESET = 5'd6;

    localparam logic [KIND_W-1:0] KIND_PROBE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FILL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INDEX,
        S_READ,
        S_CMP
    } t_state;

    typedef struct packed {
        logic load_item;
        logic idx_step;
        logic mem_rd;
        logic commit;
        logic clr_step;
    } t_dp_cmd;

    typedef struct packed {
        logic idx_done;
        logic clr_done;
        logic out_busy;
    } t_dp_sts;

endpackage

@@ rtl/core/sact_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sact_ctrl
// Sequencer: clearing pass after reset, then one word at a time through
// set index, set read and compare/update.
// ----------------------------------------------------------------------------
module sact_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  sact_pkg::t_dp_sts i_sts,
    output sact_pkg::t_dp_cmd o_cmd
);

    sact_pkg::t_state r_state;
    sact_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sact_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sact_pkg::S_CLEAR: begin
                if (i_sts.clr_done) n_state = sact_pkg::S_IDLE;
            end
            sact_pkg::S_IDLE: begin
                if (i_valid) n_state = sact_pkg::S_INDEX;
            end
            sact_pkg::S_INDEX: begin
                if (i_sts.idx_done) n_state = sact_pkg::S_READ;
            end
            sact_pkg::S_READ: begin
                n_state = sact_pkg::S_CMP;
            end
            sact_pkg::S_CMP: begin
                if (!i_sts.out_busy) n_state = sact_pkg::S_IDLE;
            end
            default: begin
                n_state = sact_pkg::S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            sact_pkg::S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
            end
            sact_pkg::S_IDLE: begin
                o_ready         = 1'b1;
                o_cmd.load_item = i_valid;
            end
            sact_pkg::S_INDEX: begin
                o_cmd.idx_step = 1'b1;
            end
            sact_pkg::S_READ: begin
                o_cmd.mem_rd = 1'b1;
            end
            sact_pkg::S_CMP: begin
                // hold until the output register can take the word
                o_cmd.commit = !i_sts.out_busy;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

@@ rtl/core/sact_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sact_dp
// Datapath: line offset register, set index unit, per-set metadata memory,
// per-way address memories, way compare, victim choice, counters and the
// output register.
// ----------------------------------------------------------------------------
module sact_dp #(
    parameter int SETS = 64,
    parameter int WAYS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sact_pkg::LOFF_W-1:0]   i_cfg_data,
    input  logic [sact_pkg::KIND_W-1:0]   i_kind,
    input  logic [sact_pkg::ADDR_W-1:0]   i_address,
    input  sact_pkg::t_dp_cmd             i_cmd,
    output sact_pkg::t_dp_sts             o_sts,
    input  logic                          i_ready,
    output logic                          o_valid,
    output logic                          o_hit,
    output logic [sact_pkg::CNT_W-1:0]    o_access_total,
    output logic [sact_pkg::CNT_W-1:0]    o_hit_total
);

    localparam int SW     = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int LW     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int MW     = WAYS + LW;
    localparam int FOLD_W = 30;
    localparam bit POW2   = ((SETS & (SETS - 1)) == 0);
    localparam logic [SW-1:0] SET_LAST = SW'(SETS - 1);
    localparam logic [LW-1:0] WAY_LAST = LW'(WAYS - 1);
    // weight of each 16-bit chunk of the shifted address, mod SETS
    localparam logic [SW-1:0] FOLD_K0 = SW'(64'd1 % 64'(SETS));
    localparam logic [SW-1:0] FOLD_K1 = SW'((64'd1 << 16) % 64'(SETS));
    localparam logic [SW-1:0] FOLD_K2 = SW'((64'd1 << 32) % 64'(SETS));
    localparam logic [SW-1:0] FOLD_K3 = SW'((64'd1 << 48) % 64'(SETS));
    localparam logic [FOLD_W-1:0] SETS_F = FOLD_W'(SETS);
    localparam logic [FOLD_W:0]   RECIP  = (FOLD_W + 1)'((64'd1 << FOLD_W) / 64'(SETS));
    localparam logic [2:0] IDX_QUOT = 3'd4;
    localparam logic [2:0] IDX_SUB  = 3'd5;
    localparam logic [2:0] IDX_LAST = 3'd6;

    logic [sact_pkg::LOFF_W-1:0] r_line_off;
    logic [sact_pkg::KIND_W-1:0] r_kind;
    logic [sact_pkg::ADDR_W-1:0] r_addr;
    logic [sact_pkg::ADDR_W-1:0] r_shift;
    logic [SW-1:0]               r_rem;
    logic [FOLD_W-1:0]           r_fold;
    logic [FOLD_W-1:0]           r_q;
    logic [2:0]                  r_idx_cnt;
    logic [SW-1:0]               r_clr_cnt;
    logic [MW-1:0]               r_meta_rd;
    logic [sact_pkg::ADDR_W-1:0] r_way_rd [WAYS];
    logic [sact_pkg::CNT_W-1:0]  r_acc;
    logic [sact_pkg::CNT_W-1:0]  r_hits;
    logic                        r_out_valid;
    logic                        r_out_hit;
    logic [sact_pkg::CNT_W-1:0]  r_out_acc;
    logic [sact_pkg::CNT_W-1:0]  r_out_hits;

    logic [MW-1:0] meta_mem [SETS];

    logic [sact_pkg::CNT_W-1:0] n_acc;
    logic [sact_pkg::CNT_W-1:0] n_hits;
    logic [15:0]                w_chunk;
    logic [SW-1:0]              w_weight;
    logic [FOLD_W-1:0]          w_fold_term;
    logic [2*FOLD_W:0]          w_q_prod;
    logic [FOLD_W-1:0]          w_qm;
    logic [FOLD_W-1:0]          w_rem_sub;
    logic [SW-1:0]              w_rem_n;
    logic [SW-1:0]              w_set;
    logic [WAYS-1:0]            w_valid;
    logic [LW-1:0]              w_last;
    logic [WAYS-1:0]            w_match;
    logic                       w_hit;
    logic                       w_any_inv;
    logic [LW-1:0]              w_first_inv;
    logic [LW-1:0]              w_rr;
    logic [LW-1:0]              w_victim;
    logic [WAYS-1:0]            w_victim_oh;
    logic                       w_is_acc;
    logic                       w_fill;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_off <= sact_pkg::LOFF_RESET;
        end else if (i_cfg_we) begin
            r_line_off <= i_cfg_data;
        end
    end

    // set index: mask for a power-of-two set count; otherwise fold the four
    // 16-bit chunks by their weights, then reduce by a reciprocal multiply
    always_comb begin
        unique case (r_idx_cnt[1:0])
            2'd0: begin
                w_chunk  = r_shift[15:0];
                w_weight = FOLD_K0;
            end
            2'd1: begin
                w_chunk  = r_shift[31:16];
                w_weight = FOLD_K1;
            end
            2'd2: begin
                w_chunk  = r_shift[47:32];
                w_weight = FOLD_K2;
            end
            2'd3: begin
                w_chunk  = r_shift[63:48];
                w_weight = FOLD_K3;
            end
        endcase
    end

    assign w_fold_term = FOLD_W'(w_chunk) * FOLD_W'(w_weight);
    assign w_q_prod    = r_fold * RECIP;
    assign w_qm        = r_q * SETS_F;
    assign w_rem_sub   = r_fold - SETS_F;
    // the reciprocal quotient is low by at most one: one subtract finishes
    assign w_rem_n     = (r_fold >= SETS_F) ? w_rem_sub[SW-1:0] : r_fold[SW-1:0];
    assign w_set       = POW2 ? (r_shift[SW-1:0] & SET_LAST) : r_rem;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_kind    <= i_kind;
            r_addr    <= i_address;
            r_shift   <= i_address >> r_line_off;
            r_fold    <= '0;
            r_idx_cnt <= '0;
        end else if (i_cmd.idx_step) begin
            r_idx_cnt <= r_idx_cnt + 1'b1;
            unique case (r_idx_cnt)
                IDX_QUOT: begin
                    r_q <= w_q_prod[2*FOLD_W-1:FOLD_W];
                end
                IDX_SUB: begin
                    r_fold <= r_fold - w_qm;
                end
                IDX_LAST: begin
                    r_rem <= w_rem_n;
                end
                default: begin
                    r_fold <= r_fold + w_fold_term;
                end
            endcase
        end
    end

    // clearing pass over the metadata rows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    // way compare and victim choice
    assign w_valid = r_meta_rd[WAYS-1:0];
    assign w_last  = r_meta_rd[MW-1:WAYS];

    always_comb begin
        w_any_inv   = 1'b0;
        w_first_inv = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            w_match[w] = w_valid[w] && (r_way_rd[w] == r_addr);
            if (!w_valid[w]) begin
                w_any_inv   = 1'b1;
                w_first_inv = LW'(w);
            end
        end
    end

    assign w_hit       = |w_match;
    assign w_rr        = (w_last == WAY_LAST) ? '0 : (w_last + 1'b1);
    assign w_victim    = w_any_inv ? w_first_inv : w_rr;
    assign w_victim_oh = WAYS'(1) << w_victim;
    assign w_is_acc    = (r_kind == sact_pkg::KIND_PROBE) || (r_kind == sact_pkg::KIND_FILL);
    assign w_fill      = i_cmd.commit && (r_kind == sact_pkg::KIND_FILL) && !w_hit;

    // metadata memory: valid bits and last filled way per set
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            meta_mem[r_clr_cnt] <= '0;
        end else if (w_fill) begin
            meta_mem[w_set] <= {w_victim, w_valid | w_victim_oh};
        end
        if (i_cmd.mem_rd) begin
            r_meta_rd <= meta_mem[w_set];
        end
    end

    // one address memory per way
    for (genvar g = 0; g < WAYS; g++) begin : g_way
        logic [sact_pkg::ADDR_W-1:0] addr_mem [SETS];

        always_ff @(posedge i_clk) begin
            if (w_fill && (w_victim == LW'(g))) begin
                addr_mem[w_set] <= r_addr;
            end
            if (i_cmd.mem_rd) begin
                r_way_rd[g] <= addr_mem[w_set];
            end
        end
    end

    // saturating counters
    always_comb begin
        n_acc  = r_acc;
        n_hits = r_hits;
        unique case (r_kind)
            sact_pkg::KIND_PROBE, sact_pkg::KIND_FILL: begin
                if (r_acc != '1) n_acc = r_acc + 1'b1;
                if (w_hit && (r_hits != '1)) n_hits = r_hits + 1'b1;
            end
            sact_pkg::KIND_CLEAR: begin
                n_acc  = '0;
                n_hits = '0;
            end
            default: begin
                n_acc  = r_acc;
                n_hits = r_hits;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_hits <= '0;
        end else if (i_cmd.commit) begin
            r_acc  <= n_acc;
            r_hits <= n_hits;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_hit  <= w_is_acc && w_hit;
            r_out_acc  <= n_acc;
            r_out_hits <= n_hits;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_hit          = r_out_hit;
    assign o_access_total = r_out_acc;
    assign o_hit_total    = r_out_hits;

    assign o_sts.idx_done = POW2 ? 1'b1 : (r_idx_cnt == IDX_LAST);
    assign o_sts.clr_done = (r_clr_cnt == SET_LAST);
    assign o_sts.out_busy = r_out_valid && !i_ready;

endmodule

@@ rtl/core/set_assoc_cache_tag_store_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_store_unit
// Set-associative tag store that fills the lowest invalid way first, else
// replaces round robin, with saturating access and hit counters.
//
//   channel  | valid / ready        | payload
//   ---------+----------------------+-----------------------------------------
//   in       | i_valid / o_ready    | i_kind, i_address
//   out      | o_valid / i_ready    | o_hit, o_access_total, o_hit_total
//   config   | i_cfg_we (no wait)   | i_cfg_data (line offset bits)
//
// One word is in flight at a time. With a power-of-two SETS a word goes
// through accept, index, set read, compare and update. Otherwise the set
// index state folds the four 16-bit chunks by their weights and reduces the
// sum by a reciprocal multiply. After reset a clearing pass writes every
// metadata row with o_ready low. A stalled output holds the compare stage;
// the next word is accepted while the result register still waits.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_store_unit #(
    parameter int SETS = 64,
    parameter int WAYS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sact_pkg::LOFF_W-1:0]   i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [sact_pkg::KIND_W-1:0]   i_kind,
    input  logic [sact_pkg::ADDR_W-1:0]   i_address,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_hit,
    output logic [sact_pkg::CNT_W-1:0]    o_access_total,
    output logic [sact_pkg::CNT_W-1:0]    o_hit_total
);

    sact_pkg::t_dp_cmd w_cmd;
    sact_pkg::t_dp_sts w_sts;

    sact_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    sact_dp #(
        .SETS (SETS),
        .WAYS (WAYS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_kind         (i_kind),
        .i_address      (i_address),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_hit          (o_hit),
        .o_access_total (o_access_total),
        .o_hit_total    (o_hit_total)
    );

    // one word in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("accepted a second word while one is in flight");

    // never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> !(o_valid && !i_ready))
        else $error("result register overwritten while stalled");

    // hits never outnumber accesses
    a_hits_le_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hit_total <= o_access_total))
        else $error("hit total exceeds access total");

    // a reported hit has been counted
    a_hit_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> (o_hit_total != '0))
        else $error("hit reported with zero hit total");

endmodule

@@ test/set_assoc_cache_tag_store_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_store_unit_test
// Drives probe, fill, clear and unused-kind words into the tag store under
// several line-offset settings and checks every result word against a
// hand-written expectation or a behavioral copy of the sets, round-robin
// pointers and saturating counters. Both handshakes are stalled in random
// bursts except in the closing phase.
module set_assoc_cache_tag_store_unit_test;

    localparam int SETS           = 64;
    localparam int WAYS           = 4;
    localparam int N_DIR          = 26;
    localparam int N_PHASES       = 6;
    localparam int PHASE_WORDS    = 115;
    localparam int POOL_SIZE      = 14;
    localparam int WATCHDOG_LIMIT = 4000;

    // the fourth kind code has no package name; the block ignores it
    localparam logic [sact_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic                       hit;
        logic [sact_pkg::CNT_W-1:0] acc;
        logic [sact_pkg::CNT_W-1:0] hits;
    } tag_result_t;

    typedef struct packed {
        logic [sact_pkg::KIND_W-1:0] kind;
        logic [sact_pkg::ADDR_W-1:0] addr;
        logic                        fixed;
        logic                        hit;
        logic [sact_pkg::CNT_W-1:0]  acc;
        logic [sact_pkg::CNT_W-1:0]  hits;
    } stim_row_t;

    logic                         i_clk          = 1'b0;
    logic                         i_rst_n        = 1'b0;
    logic                         i_cfg_we       = 1'b0;
    logic [sact_pkg::LOFF_W-1:0]  i_cfg_data     = '0;
    logic                         i_valid        = 1'b0;
    logic [sact_pkg::KIND_W-1:0]  i_kind         = sact_pkg::KIND_PROBE;
    logic [sact_pkg::ADDR_W-1:0]  i_address      = '0;
    logic                         i_ready        = 1'b0;
    logic                         o_ready;
    logic                         o_valid;
    logic                         o_hit;
    logic [sact_pkg::CNT_W-1:0]   o_access_total;
    logic [sact_pkg::CNT_W-1:0]   o_hit_total;

    // directed words; fixed rows carry a hand-written expected result
    stim_row_t dir_rows [N_DIR] = '{
        '{sact_pkg::KIND_PROBE, 64'h0,                  1'b1, 1'b0, 32'd1, 32'd0},
        '{sact_pkg::KIND_FILL,  64'h0,                  1'b1, 1'b0, 32'd2, 32'd0},
        '{sact_pkg::KIND_PROBE, 64'h0,                  1'b1, 1'b1, 32'd3, 32'd1},
        '{sact_pkg::KIND_FILL,  64'h0,                  1'b1, 1'b1, 32'd4, 32'd2},
        '{sact_pkg::KIND_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 32'd5, 32'd2},
        '{sact_pkg::KIND_FILL,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 32'd6, 32'd2},
        '{sact_pkg::KIND_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 32'd7, 32'd3},
        '{KIND_UNUSED,          64'h0,                  1'b1, 1'b0, 32'd7, 32'd3},
        '{sact_pkg::KIND_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 32'd0, 32'd0},
        '{KIND_UNUSED,          64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 32'd0, 32'd0},
        // same set as address zero, differs only in the top bit
        '{sact_pkg::KIND_PROBE, 64'h8000_0000_0000_0000, 1'b0, 1'b0, 32'd0, 32'd0},
        '{sact_pkg::KIND_FILL,  64'h8000_0000_0000_0000, 1'b0, 1'b0, 32'd0, 32'd0},
        // fill set 1 completely, then wrap the round-robin pointer
        '{sact_pkg::KIND_FILL,  64'h0000_0000_0000_0040, 1'b0, 1'b0, 32'd0, 32'd0},
        '{sact_pkg::KIND_FILL,  64'h0000_0000_0000_1040, 1'b0, 1'b0, 32'd0, 32'd0},
        '{sact_pkg::KIND_FILL,  64'h0000_0000_0000_2040, 1'b0, 1'b0, 32'd0, 32'd0},
        '{sact_pkg::KIND_FILL,  64'h0000_0000_0000_3040, 1'b0, 1'b0, 32'd0, 32'd0},
        '{sact_pkg::KIND_FILL,  64'h0000_0000_0000_4040, 1'b0, 1'b0, 32'd0, 32'd0},
        '{sact_pkg::KIND_PROBE, 64'h0000_0000_0000_0040, 1'b0, 1'b0, 32'd0, 32'd0},
        '{sact_pkg::KIND_PROBE, 64'h0000_0000_0000_1040, 1'b0, 1'b0, 32'd0, 32'd0},
        '{sact_pkg::KIND_FILL,  64'h0000_0000_0000_3040, 1'b0, 1'b0, 32'd0, 32'd0},
        '{sact_pkg::KIND_FILL,  64'h0000_0000_0000_5040, 1'b0, 1'b0, 32'd0, 32'd0},
        '{sact_pkg::KIND_PROBE, 64'h0000_0000_0000_1040, 1'b0, 1'b0, 32'd0, 32'd0},
        '{sact_pkg::KIND_FILL,  64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 32'd0, 32'd0},
        '{sact_pkg::KIND_PROBE, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 32'd0, 32'd0},
        '{sact_pkg::KIND_FILL,  64'h5555_5555_5555_5555, 1'b0, 1'b0, 32'd0, 32'd0},
        '{sact_pkg::KIND_PROBE, 64'h5555_5555_5555_5555, 1'b0, 1'b0, 32'd0, 32'd0}
    };

    // behavioral copy of the tag store
    logic                        line_live [SETS*WAYS];
    logic [sact_pkg::ADDR_W-1:0] line_addr [SETS*WAYS];
    int unsigned                 last_fill [SETS];
    logic [sact_pkg::CNT_W-1:0]  n_access;
    logic [sact_pkg::CNT_W-1:0]  n_hit;
    logic [sact_pkg::LOFF_W-1:0] shift_bits;

    tag_result_t tag_results_q [$];
    tag_result_t head;

    bit gaps_on;
    int stall_left;
    int quiet_cycles;
    int mismatches;
    int words_sent;
    int hits_seen;
    int evictions;
    int clears_seen;
    int settings_used;

    set_assoc_cache_tag_store_unit #(
        .SETS (SETS),
        .WAYS (WAYS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_kind         (i_kind),
        .i_address      (i_address),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_hit          (o_hit),
        .o_access_total (o_access_total),
        .o_hit_total    (o_hit_total)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic tag_result_t tag_access(input logic [sact_pkg::KIND_W-1:0] kind,
                                                input logic [sact_pkg::ADDR_W-1:0] addr);
        tag_result_t r;
        int          set_i;
        int          base;
        int          victim;
        int          w;
        r.hit = 1'b0;
        if (kind == sact_pkg::KIND_CLEAR) begin
            n_access = '0;
            n_hit    = '0;
            clears_seen++;
        end else if (kind == sact_pkg::KIND_PROBE || kind == sact_pkg::KIND_FILL) begin
            set_i = int'((addr >> shift_bits) % 64'(SETS));
            base  = set_i * WAYS;
            if (n_access != '1) n_access++;
            for (w = 0; w < WAYS; w++) begin
                if (line_live[base+w] && line_addr[base+w] == addr) r.hit = 1'b1;
            end
            if (r.hit) begin
                if (n_hit != '1) n_hit++;
                hits_seen++;
            end
            if (kind == sact_pkg::KIND_FILL && !r.hit) begin
                // lowest invalid way first, else advance the round-robin pointer
                victim = WAYS;
                for (w = WAYS - 1; w >= 0; w--) begin
                    if (!line_live[base+w]) victim = w;
                end
                if (victim == WAYS) begin
                    victim = (last_fill[set_i] + 1) % WAYS;
                    evictions++;
                end
                line_live[base+victim] = 1'b1;
                line_addr[base+victim] = addr;
                last_fill[set_i]       = victim;
            end
        end
        r.acc  = n_access;
        r.hits = n_hit;
        return r;
    endfunction

    // hold the word until accepted; valid stays high into the next word unless a gap is drawn
    task automatic send_word(input logic [sact_pkg::KIND_W-1:0] kind,
                             input logic [sact_pkg::ADDR_W-1:0] addr,
                             input logic fixed, input tag_result_t fixed_res);
        tag_result_t r;
        int          gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_kind    <= kind;
        i_address <= addr;
        do @(posedge i_clk); while (!o_ready);
        r = tag_access(kind, addr);
        tag_results_q.insert(tag_results_q.size(), fixed ? fixed_res : r);
        words_sent++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (tag_results_q.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic set_line_offset(input logic [sact_pkg::LOFF_W-1:0] offs);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= offs;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        shift_bits = offs;
        settings_used++;
    endtask

    // result side: check, then pick ready for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (tag_results_q.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result word: hit=%0d acc=%0d hits=%0d",
                             o_hit, o_access_total, o_hit_total);
                mismatches++;
            end else begin
                head = tag_results_q.pop_front();
                if (o_hit !== head.hit || o_access_total !== head.acc ||
                    o_hit_total !== head.hits) begin
                    if (mismatches < 10)
                        $display("mismatch: hit %0d/%0d acc %0d/%0d hits %0d/%0d (exp/act)",
                                 head.hit, o_hit, head.acc, o_access_total,
                                 head.hits, o_hit_total);
                    mismatches++;
                end
            end
        end
        if (!gaps_on) begin
            // drop any stall left over once idling is switched off
            stall_left = 0;
            i_ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 17) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", quiet_cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        int                          k;
        int                          n;
        int                          ph;
        int                          r;
        int                          offs_plan [N_PHASES];
        int                          sets_pick [3];
        logic [sact_pkg::LOFF_W-1:0] offs;
        logic [sact_pkg::KIND_W-1:0] kind;
        logic [sact_pkg::ADDR_W-1:0] addr;
        logic [sact_pkg::ADDR_W-1:0] base;
        logic [sact_pkg::ADDR_W-1:0] pool [POOL_SIZE];
        tag_result_t                 fixed_res;

        for (k = 0; k < SETS * WAYS; k++) begin
            line_live[k] = 1'b0;
            line_addr[k] = '0;
        end
        for (k = 0; k < SETS; k++) last_fill[k] = 0;
        n_access      = '0;
        n_hit         = '0;
        shift_bits    = sact_pkg::LOFF_RESET;
        settings_used = 1;
        gaps_on       = 1'b1;
        offs_plan     = '{0, 31, 16, 0, 6, 0};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < N_DIR; k++) begin
            fixed_res = '{dir_rows[k].hit, dir_rows[k].acc, dir_rows[k].hits};
            send_word(dir_rows[k].kind, dir_rows[k].addr, dir_rows[k].fixed, fixed_res);
        end

        for (ph = 0; ph < N_PHASES; ph++) begin
            wait_drained();
            offs = (ph == 3 || ph == 5) ? sact_pkg::LOFF_W'($urandom_range(0, 31))
                                        : sact_pkg::LOFF_W'(offs_plan[ph]);
            set_line_offset(offs);
            // the closing phase runs without stalls
            gaps_on = (ph != N_PHASES - 1);
            for (k = 0; k < 3; k++) sets_pick[k] = $urandom_range(0, SETS - 1);
            // crowd a few sets so hits and evictions both happen
            for (k = 0; k < POOL_SIZE; k++) begin
                base    = {$urandom, $urandom};
                pool[k] = (base & ~(64'h3F << offs)) | (64'(sets_pick[k % 3]) << offs);
            end
            for (n = 0; n < PHASE_WORDS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 5)       kind = sact_pkg::KIND_CLEAR;
                else if (r < 10) kind = KIND_UNUSED;
                else if (r < 55) kind = sact_pkg::KIND_PROBE;
                else             kind = sact_pkg::KIND_FILL;
                if ($urandom_range(0, 9) == 0) addr = {$urandom, $urandom};
                else                           addr = pool[$urandom_range(0, POOL_SIZE - 1)];
                send_word(kind, addr, 1'b0, '0);
            end
        end
        wait_drained();

        $display("Sent %0d words over %0d line-offset settings (0 and 31 included).",
                 words_sent, settings_used);
        $display("Saw %0d hits, %0d round-robin evictions, %0d counter clears; %0d mismatches.",
                 hits_seen, evictions, clears_seen, mismatches);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
